// File: rtl/core/uer_pkg.sv
// shared types, register map and constants of the ultrasonic echo ranger
package uer_pkg;

  localparam int CNT_BITS_DEF = 16;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  // register map, word index of paddr
  typedef enum logic [1:0] {
    REG_TIMEOUT    = 2'd0,
    REG_MIN_STABLE = 2'd1,
    REG_MIN_DIST   = 2'd2,
    REG_MAX_DIST   = 2'd3
  } reg_idx_t;

  localparam logic [15:0] TIMEOUT_RST    = 16'd30000;
  localparam logic [15:0] MIN_STABLE_RST = 16'd0;
  localparam logic [18:0] MIN_DIST_RST   = 19'd512;
  localparam logic [18:0] MAX_DIST_RST   = 19'd102400;

  // status codes
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RISING  = 3'd1;
  localparam logic [2:0] ST_FALLING = 3'd2;
  localparam logic [2:0] ST_DONE    = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_RANGE   = 3'd5;

  localparam logic [3:0] TRIG_LOW_TICKS  = 4'd2;
  localparam logic [3:0] TRIG_HIGH_TICKS = 4'd10;

  // distance = width * 281 >> 6 in 1/256 cm
  localparam logic [8:0] DIST_MUL   = 9'd281;
  localparam int         DIST_SHIFT = 6;
  localparam int         PROD_W     = 25;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } item_t;

  typedef struct packed {
    logic        trigger_level;
    logic        busy_res;
    logic [2:0]  status;
    logic [15:0] echo_time;
    logic [18:0] distance_q8;
    logic        finished;
  } res_t;

  typedef struct packed {
    logic [15:0] limit_us;
    logic [15:0] min_stable_echo_us;
    logic [18:0] min_distance_q8;
    logic [18:0] max_distance_q8;
  } cfg_t;

endpackage

// File: rtl/core/uer_cfg.sv
// apb configuration registers of the echo ranger
module uer_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [uer_pkg::DATA_W-1:0] pwdata,
  output logic [uer_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output uer_pkg::cfg_t              cfg
);
  import uer_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit_us           <= TIMEOUT_RST;
      cfg.min_stable_echo_us <= MIN_STABLE_RST;
      cfg.min_distance_q8    <= MIN_DIST_RST;
      cfg.max_distance_q8    <= MAX_DIST_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_TIMEOUT:    cfg.limit_us           <= pwdata[15:0];
        REG_MIN_STABLE: cfg.min_stable_echo_us <= pwdata[15:0];
        REG_MIN_DIST:   cfg.min_distance_q8    <= pwdata[18:0];
        REG_MAX_DIST:   cfg.max_distance_q8    <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TIMEOUT:    prdata = DATA_W'(cfg.limit_us);
      REG_MIN_STABLE: prdata = DATA_W'(cfg.min_stable_echo_us);
      REG_MIN_DIST:   prdata = DATA_W'(cfg.min_distance_q8);
      REG_MAX_DIST:   prdata = DATA_W'(cfg.max_distance_q8);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/uer_ctrl.sv
// ranging sequencer: trigger pulse, echo edge timing and distance check per tick
module uer_ctrl #(
  parameter int COUNTER_BITS = uer_pkg::CNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  uer_pkg::item_t item,
  input  uer_pkg::cfg_t  cfg,
  output uer_pkg::res_t  res
);
  import uer_pkg::*;

  localparam int TW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_LOW  = 3'd1,
    PH_TRIG_LOW  = 3'd2,
    PH_TRIG_HIGH = 3'd3,
    PH_WAIT_RISE = 3'd4,
    PH_WAIT_FALL = 3'd5
  } phase_t;

  phase_t                  phase, phase_next;
  logic [COUNTER_BITS-1:0] tick_count, tick_count_next;
  logic [3:0]              trigger_count, trigger_count_next;
  logic [COUNTER_BITS-1:0] pulse_start, pulse_start_next;
  logic [15:0]             last_short_echo, last_short_echo_next;
  logic [2:0]              status_reg, status_reg_next;
  logic [15:0]             echo_time_reg, echo_time_reg_next;
  logic [18:0]             distance_reg, distance_reg_next;

  logic                    timed_out;
  logic [COUNTER_BITS-1:0] tick_adv;
  logic [COUNTER_BITS-1:0] diff;
  logic [15:0]             width;
  logic [PROD_W-1:0]       prod;
  logic [18:0]             range_q8;
  logic [3:0]              trig_inc;
  logic                    fin;

  assign timed_out = (TW'(tick_count) >= TW'(cfg.limit_us)) || (tick_count == CNT_MAX);
  assign tick_adv  = (tick_count == CNT_MAX) ? tick_count : tick_count + 1'b1;
  assign diff      = tick_count - pulse_start;
  assign width     = (diff > COUNTER_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(diff);
  assign prod      = PROD_W'(width) * PROD_W'(DIST_MUL);
  assign range_q8  = 19'(prod >> DIST_SHIFT);
  assign trig_inc  = trigger_count + 4'd1;

  always_comb begin
    phase_next           = phase;
    tick_count_next      = tick_count;
    trigger_count_next   = trigger_count;
    pulse_start_next     = pulse_start;
    last_short_echo_next = last_short_echo;
    status_reg_next      = status_reg;
    echo_time_reg_next   = echo_time_reg;
    distance_reg_next    = distance_reg;
    fin                  = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (item.start_req) begin
          phase_next           = PH_WAIT_LOW;
          tick_count_next      = '0;
          last_short_echo_next = '0;
          echo_time_reg_next   = '0;
          status_reg_next      = ST_RISING;
        end
      end
      PH_WAIT_LOW: begin
        if (!item.echo_level) begin
          phase_next         = PH_TRIG_LOW;
          trigger_count_next = '0;
        end else if (timed_out) begin
          status_reg_next = ST_TIMEOUT;
          phase_next      = PH_IDLE;
          fin             = 1'b1;
        end else begin
          tick_count_next = tick_adv;
        end
      end
      PH_TRIG_LOW: begin
        trigger_count_next = trig_inc;
        if (trig_inc >= TRIG_LOW_TICKS) begin
          phase_next         = PH_TRIG_HIGH;
          trigger_count_next = '0;
        end
      end
      PH_TRIG_HIGH: begin
        trigger_count_next = trig_inc;
        if (trig_inc >= TRIG_HIGH_TICKS) begin
          phase_next         = PH_WAIT_RISE;
          trigger_count_next = '0;
          tick_count_next    = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (timed_out) begin
          status_reg_next    = (last_short_echo != '0) ? ST_RANGE : ST_TIMEOUT;
          echo_time_reg_next = last_short_echo;
          phase_next         = PH_IDLE;
          fin                = 1'b1;
        end else begin
          if (item.echo_level) begin
            pulse_start_next = tick_count;
            status_reg_next  = ST_FALLING;
            phase_next       = PH_WAIT_FALL;
          end
          tick_count_next = tick_adv;
        end
      end
      PH_WAIT_FALL: begin
        if (item.echo_level) begin
          if (timed_out) begin
            status_reg_next    = ST_TIMEOUT;
            echo_time_reg_next = width;
            phase_next         = PH_IDLE;
            fin                = 1'b1;
          end else begin
            tick_count_next = tick_adv;
          end
        end else begin
          echo_time_reg_next = width;
          if (width < cfg.min_stable_echo_us) begin
            // short pulse: remember it and keep listening
            last_short_echo_next = width;
            status_reg_next      = ST_RISING;
            phase_next           = PH_WAIT_RISE;
            tick_count_next      = tick_adv;
          end else begin
            if (range_q8 >= cfg.min_distance_q8 && range_q8 <= cfg.max_distance_q8) begin
              distance_reg_next = range_q8;
              status_reg_next   = ST_DONE;
            end else begin
              status_reg_next = ST_RANGE;
            end
            phase_next = PH_IDLE;
            fin        = 1'b1;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    res.trigger_level = (phase == PH_TRIG_HIGH);
    res.busy_res      = (status_reg_next == ST_RISING) || (status_reg_next == ST_FALLING);
    res.status        = status_reg_next;
    res.echo_time     = echo_time_reg_next;
    res.distance_q8   = distance_reg_next;
    res.finished      = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_count      <= '0;
      trigger_count   <= '0;
      pulse_start     <= '0;
      last_short_echo <= '0;
      status_reg      <= ST_IDLE;
      echo_time_reg   <= '0;
      distance_reg    <= '0;
    end else if (step) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      trigger_count   <= trigger_count_next;
      pulse_start     <= pulse_start_next;
      last_short_echo <= last_short_echo_next;
      status_reg      <= status_reg_next;
      echo_time_reg   <= echo_time_reg_next;
      distance_reg    <= distance_reg_next;
    end
  end

endmodule

// File: rtl/core/uer_outbuf.sv
// result register with skid stage
module uer_outbuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uer_pkg::res_t push_data,
  output logic          full,
  output logic          result_valid,
  input  logic          result_stall,
  output uer_pkg::res_t result
);
  import uer_pkg::*;

  logic skid_valid;
  res_t skid;
  logic pop;

  assign pop  = result_valid && !result_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (!result_valid || pop) begin
        if (skid_valid) begin
          result       <= skid;
          result_valid <= 1'b1;
          skid_valid   <= push;
          skid         <= push_data;
        end else begin
          result       <= push_data;
          result_valid <= push;
        end
      end else if (push) begin
        skid       <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/ultrasonic_echo_ranger_core.sv
// top level of the ultrasonic echo ranger
// usage:
// - item channel (item_valid / item_stall / item) carries one microsecond tick:
//   the sampled echo level and a start request; every tick must be sent
// - result channel (result_valid / result_stall / result) returns one result
//   per tick: trigger pin level, busy, status, echo width, distance, finished
// - apb port sets timeout, minimum stable echo width and the distance window;
//   write it only while no tick is in flight
// - an accepted tick is held in the input register, then its result goes to the
//   result register, or to the skid stage while the receiver stalls
// - throughput: one tick per cycle while item_stall is low
// - when the receiver stalls, the skid stage takes one more result, then
//   item_stall rises until the result register drains
// - reset clears the sequencer to idle, status to idle, widths and distance
//   to zero, and the configuration to its defaults
module ultrasonic_echo_ranger_core #(
  parameter int COUNTER_BITS = uer_pkg::CNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  uer_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output uer_pkg::res_t              result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [uer_pkg::DATA_W-1:0] pwdata,
  output logic [uer_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import uer_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  logic  item_q_valid;
  logic  full;
  logic  push;
  logic  accept;
  res_t  res;

  assign item_stall = item_q_valid && full;
  assign accept     = item_valid && !item_stall;
  assign push       = item_q_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else begin
      item_q_valid <= accept || (item_q_valid && full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  uer_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  uer_ctrl #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (push),
    .item (item_q),
    .cfg  (cfg),
    .res  (res)
  );

  uer_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (res),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: rtl/core/uer_checker.sv
// port-level checks of the echo ranger, bound to the top level
module uer_checker (
  input logic          clk,
  input logic          rst,
  input logic          result_valid,
  input logic          result_stall,
  input uer_pkg::res_t result
);
  import uer_pkg::*;

  a_after_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_finished_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.finished |->
      (result.status == ST_DONE || result.status == ST_TIMEOUT ||
       result.status == ST_RANGE))
    else $error("finished without a final status");

  a_busy_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.busy_res == (result.status == ST_RISING || result.status == ST_FALLING)))
    else $error("busy does not match status");

  a_trigger_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.trigger_level |->
      result.busy_res && result.status == ST_RISING && !result.finished)
    else $error("trigger driven outside a measurement");

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
